### rtl/core/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types and constants of the barometer compensation block.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int unsigned NUM_REGS = 6;

  localparam logic [2:0] REG_T1_T2 = 3'd0;
  localparam logic [2:0] REG_T3_P1 = 3'd1;
  localparam logic [2:0] REG_P2_P3 = 3'd2;
  localparam logic [2:0] REG_P4_P5 = 3'd3;
  localparam logic [2:0] REG_P6_P7 = 3'd4;
  localparam logic [2:0] REG_P8_P9 = 3'd5;

  localparam logic [63:0] T_OFFSET   = 64'd128000;
  localparam logic [63:0] P_BASE     = 64'd1048576;
  localparam logic [63:0] P_SCALE    = 64'd3125;
  localparam logic [63:0] P1_BIAS    = 64'h0000_8000_0000_0000;
  localparam logic [63:0] TEMP_MUL   = 64'd5;
  localparam logic [31:0] TEMP_ROUND = 32'd128;

  typedef struct packed {
    logic [31:0] t1_t2;
    logic [31:0] t3_p1;
    logic [31:0] p2_p3;
    logic [31:0] p4_p5;
    logic [31:0] p6_p7;
    logic [31:0] p8_p9;
  } coef_t;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } sample_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_MWAIT,
    S_DIV,
    S_DWAIT,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_TV1,
    OP_DSQ,
    OP_TV2,
    OP_TEMP,
    OP_SQ,
    OP_V2A,
    OP_V2B,
    OP_UA,
    OP_UB,
    OP_VD,
    OP_NUM,
    OP_W,
    OP_PV1,
    OP_PV2
  } op_t;

endpackage

### rtl/core/bptc_front.sv
// ----------------------------------------------------------------------------
// bptc_front
// Coefficient registers, input acceptance and a two-entry request queue.
// ----------------------------------------------------------------------------
module bptc_front import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output coef_t       coef,
  output logic        q_valid,
  input  logic        q_ready,
  output sample_t     q_data
);

  sample_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  logic       wr_en;

  assign pready        = 1'b1;
  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign pop           = q_valid && q_ready;
  assign q_data        = mem[rd_ptr];
  assign wr_en         = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= sample_t'(s_axis_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_T1_T2: coef.t1_t2 <= pwdata;
        REG_T3_P1: coef.t3_p1 <= pwdata;
        REG_P2_P3: coef.p2_p3 <= pwdata;
        REG_P4_P5: coef.p4_p5 <= pwdata;
        REG_P6_P7: coef.p6_p7 <= pwdata;
        REG_P8_P9: coef.p8_p9 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_T1_T2: prdata = coef.t1_t2;
      REG_T3_P1: prdata = coef.t3_p1;
      REG_P2_P3: prdata = coef.p2_p3;
      REG_P4_P5: prdata = coef.p4_p5;
      REG_P6_P7: prdata = coef.p6_p7;
      REG_P8_P9: prdata = coef.p8_p9;
      default:   prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/bptc_mul.sv
// ----------------------------------------------------------------------------
// bptc_mul
// 64 x 64 multiplier, low 64 bits, from three 32 x 32 partial products.
// ----------------------------------------------------------------------------
module bptc_mul import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] part;
  logic [1:0]  phase;
  logic        busy;
  logic [31:0] mx;
  logic [31:0] my;

  assign mx = (phase == 2'd2) ? opa[63:32] : opa[31:0];
  assign my = (phase == 2'd1) ? opb[63:32] : opb[31:0];

  always_ff @(posedge clk) begin
    if (start) begin
      opa <= a;
      opb <= b;
    end
    if (busy) begin
      part <= mx * my;
      unique case (phase)
        2'd0: ;
        2'd1: prod <= part;
        2'd2: prod <= prod + {part[31:0], 32'd0};
        2'd3: prod <= prod + {part[31:0], 32'd0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= busy && (phase == 2'd3);
      if (start) begin
        busy  <= 1'b1;
        phase <= 2'd0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) busy <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div
// Signed 64-bit divider, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bptc_div import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] q
);

  logic [63:0] dvs;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic        fin;
  logic        neg;
  logic [65:0] diff;

  assign diff = {1'b0, rem, quo[63]} - {2'd0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= b[63] ? (64'd0 - b) : b;
      quo <= a[63] ? (64'd0 - a) : a;
      rem <= 64'd0;
      neg <= a[63] ^ b[63];
    end else if (busy) begin
      if (!diff[65]) begin
        rem <= diff[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
    if (fin) begin
      q <= neg ? (64'd0 - quo) : quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == 6'd63);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) busy <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/bptc_back.sv
// ----------------------------------------------------------------------------
// bptc_back
// Compensation sequencer over the shared multiplier and divider.
// ----------------------------------------------------------------------------
module bptc_back import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  coef_t       coef,
  input  logic        q_valid,
  output logic        q_ready,
  input  sample_t     q_data,
  output logic        m_valid,
  input  logic        m_ready,
  output logic [95:0] m_data,
  output logic        m_user
);

  state_t      state, state_next;
  op_t         op, op_next;
  logic [19:0] adc_t;
  logic [19:0] adc_p;
  logic [31:0] tv1, fine, temp;
  logic [63:0] tmp, sq, v2, vd, dvd, pq, pv1, pfin;
  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_b, mul_p, div_q;
  logic [31:0] t1, t2, t3, a32, d32;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] v1, num, psh;
  logic        err;

  assign t1  = {16'd0, coef.t1_t2[15:0]};
  assign t2  = {{16{coef.t1_t2[31]}}, coef.t1_t2[31:16]};
  assign t3  = {{16{coef.t3_p1[15]}}, coef.t3_p1[15:0]};
  assign p1  = {48'd0, coef.t3_p1[31:16]};
  assign p2  = {{48{coef.p2_p3[15]}}, coef.p2_p3[15:0]};
  assign p3  = {{48{coef.p2_p3[31]}}, coef.p2_p3[31:16]};
  assign p4  = {{48{coef.p4_p5[15]}}, coef.p4_p5[15:0]};
  assign p5  = {{48{coef.p4_p5[31]}}, coef.p4_p5[31:16]};
  assign p6  = {{48{coef.p6_p7[15]}}, coef.p6_p7[15:0]};
  assign p7  = {{48{coef.p6_p7[31]}}, coef.p6_p7[31:16]};
  assign p8  = {{48{coef.p8_p9[15]}}, coef.p8_p9[15:0]};
  assign p9  = {{48{coef.p8_p9[31]}}, coef.p8_p9[31:16]};

  assign a32 = {15'd0, adc_t[19:3]} - {t1[30:0], 1'b0};
  assign d32 = {16'd0, adc_t[19:4]} - t1;
  assign v1  = {{32{fine[31]}}, fine} - T_OFFSET;
  assign num = {(P_BASE[32:0] - {13'd0, adc_p}), 31'd0} - v2;
  assign psh = 64'($signed(pq) >>> 13);
  assign err = (vd == 64'd0);

  bptc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  bptc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (dvd),
    .b     (vd),
    .done  (div_done),
    .q     (div_q)
  );

  always_comb begin
    unique case (op)
      OP_TV1:  begin mul_a = {32'd0, a32};       mul_b = {32'd0, t2}; end
      OP_DSQ:  begin mul_a = {32'd0, d32};       mul_b = {32'd0, d32}; end
      OP_TV2:  begin mul_a = {32'd0, tmp[31:0]}; mul_b = {32'd0, t3}; end
      OP_TEMP: begin mul_a = {32'd0, fine};      mul_b = TEMP_MUL; end
      OP_SQ:   begin mul_a = v1;                 mul_b = v1; end
      OP_V2A:  begin mul_a = sq;                 mul_b = p6; end
      OP_V2B:  begin mul_a = v1;                 mul_b = p5; end
      OP_UA:   begin mul_a = sq;                 mul_b = p3; end
      OP_UB:   begin mul_a = v1;                 mul_b = p2; end
      OP_VD:   begin mul_a = P1_BIAS + tmp;      mul_b = p1; end
      OP_NUM:  begin mul_a = num;                mul_b = P_SCALE; end
      OP_W:    begin mul_a = p9;                 mul_b = psh; end
      OP_PV1:  begin mul_a = tmp;                mul_b = psh; end
      OP_PV2:  begin mul_a = p8;                 mul_b = pq; end
      default: begin mul_a = 64'd0;              mul_b = 64'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      adc_t <= q_data.raw_temperature;
      adc_p <= q_data.raw_pressure;
    end
    if (div_done) pq <= div_q;
    if (mul_done) begin
      unique case (op)
        OP_TV1:  tv1  <= 32'($signed(mul_p[31:0]) >>> 11);
        OP_DSQ:  tmp  <= {32'd0, 32'($signed(mul_p[31:0]) >>> 12)};
        OP_TV2:  fine <= tv1 + 32'($signed(mul_p[31:0]) >>> 14);
        OP_TEMP: temp <= 32'($signed(mul_p[31:0] + TEMP_ROUND) >>> 8);
        OP_SQ:   sq   <= mul_p;
        OP_V2A:  v2   <= mul_p;
        OP_V2B:  v2   <= v2 + {mul_p[46:0], 17'd0} + {p4[28:0], 35'd0};
        OP_UA:   tmp  <= 64'($signed(mul_p) >>> 8);
        OP_UB:   tmp  <= tmp + {mul_p[51:0], 12'd0};
        OP_VD:   vd   <= 64'($signed(mul_p) >>> 33);
        OP_NUM:  dvd  <= mul_p;
        OP_W:    tmp  <= mul_p;
        OP_PV1:  pv1  <= 64'($signed(mul_p) >>> 25);
        OP_PV2:  pfin <= 64'($signed(pq + pv1 + 64'($signed(mul_p) >>> 19)) >>> 8)
                         + {p7[59:0], 4'd0};
        default: ;
      endcase
    end
    if (state == S_OUT && (!m_valid || m_ready)) begin
      m_data <= {(err ? 32'd0 : pfin[31:0]), fine, temp};
      m_user <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op      <= OP_TV1;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (state == S_OUT && (!m_valid || m_ready)) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    q_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          op_next    = OP_TV1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        mul_start  = 1'b1;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (mul_done) begin
          priority if (op == OP_PV2) begin
            state_next = S_OUT;
          end else if (op == OP_NUM) begin
            op_next    = OP_W;
            state_next = err ? S_OUT : S_DIV;
          end else begin
            op_next    = op_t'(op + 4'd1);
            state_next = S_ISSUE;
          end
        end
      end
      S_DIV: begin
        div_start  = 1'b1;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) state_next = S_ISSUE;
      end
      S_OUT: begin
        if (!m_valid || m_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_valid && m_user |-> m_data[95:64] == 32'd0)
    else $error("pressure not cleared on divide error");
  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MWAIT)
    else $error("multiplier result outside wait state");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DWAIT && !err)
    else $error("divider result outside wait state");
`endif

endmodule

### rtl/core/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Barometer integer compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_axis    in         raw_temperature, raw_pressure
// m_axis    out        temperature_centi, fine_temperature, pressure_q24_8;
//                      tuser divide_error
// apb       in/out     six coefficient registers at 0x00..0x14
//
// An item passes through the acceptance of the request, fourteen multiplies on
// the shared 64 x 64 multiplier, a bit-serial divide and the loading of the
// result. A zero divisor skips the divide and the last three multiplies. Two
// requests queue ahead of the sequencer and one result waits in the output
// register. Reset is synchronous, clears control state and the coefficients.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation import bptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // temperature_centi[31:0], fine_temperature[63:32],
                                      // pressure_q24_8[95:64]
  output logic        m_axis_tuser,   // divide_error[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  coef_t   coef;
  logic    q_valid;
  logic    q_ready;
  sample_t q_data;

  bptc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .coef          (coef),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (q_data)
  );

  bptc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .coef    (coef),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_user  (m_axis_tuser)
  );

endmodule
